FILE: hw/rtl/sle_pkg.sv
package sle_pkg;

	// Default list depth
	localparam int unsigned CAPACITY_DEF = 32;

	// Field widths of the command and response words
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned CNT_W   = 7;

	// Command codes
	typedef enum logic [1:0] {
		OP_FIND   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	// Response status codes
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_BAD_INSERT = 3'd2,
		ST_BAD_DELETE = 3'd3,
		ST_NOT_FOUND  = 3'd4
	} st_t;

	// Command word
	typedef struct packed {
		logic [1:0]                command;
		logic signed [VALUE_W-1:0] value;
		logic signed [POS_W-1:0]   position;
	} cmd_word_t;

	// Response word
	typedef struct packed {
		logic [2:0]       status;
		logic [IDX_W-1:0] found_index;
		logic [CNT_W-1:0] entry_count;
	} rsp_word_t;

	// Controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PLACE,
		S_FINISH
	} state_t;

	// Pointer load source
	typedef enum logic [1:0] {
		PTR_ZERO,
		PTR_COUNT,
		PTR_POS
	} ptr_sel_t;

	// Read address source
	typedef enum logic [1:0] {
		RD_PTR,
		RD_PREV,
		RD_NEXT
	} rd_sel_t;

	// Controller to datapath
	typedef struct packed {
		logic     load;
		logic     st_set;
		st_t      st_code;
		logic     found_set;
		logic     ptr_init;
		ptr_sel_t ptr_sel;
		logic     ptr_inc;
		logic     ptr_dec;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_shift;
		logic     wr_place;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     out_load;
	} dp_ctl_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       full;
		logic       empty;
		logic       ins_ok;
		logic       del_ok;
		logic       ins_at_end;
		logic       del_at_end;
		logic       match;
		logic       scan_last;
		logic       ins_next_place;
		logic       del_last;
		logic       out_free;
	} dp_sts_t;

endpackage

FILE: hw/rtl/sequential_list_engine_top.sv
// Channel  Direction  Handshake              Word
// cmd      in         cmd_valid / cmd_ready  cmd_word   (command, value, position)
// rsp      out        rsp_valid / rsp_ready  rsp_word   (status, found_index, entry_count)
//
// One command at a time. A find examines entries in turn; an insert moves
// count - position entries and then writes its own; a delete moves count - position - 1.
// A moved entry costs one registered read and then one write of the list memory.
// Reset clears the entry count and the response valid flag; list contents are not cleared.
// A stalled response holds in its register; the next command is still taken and
// waits at its finish step only until the register frees up.
module sequential_list_engine_top #(
	parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  sle_pkg::cmd_word_t cmd_word,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sle_pkg::rsp_word_t rsp_word
);
	import sle_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	sle_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_word  (cmd_word),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word)
	);

	// An accepted command leaves the engine busy in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("command accepted while previous one in flight");

	// Reported count never exceeds the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_word.entry_count <= CNT_W'(CAPACITY)))
		else $error("entry count beyond capacity");

	// A found index lies inside the list
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.found_index != '0)
			|-> (CNT_W'(rsp_word.found_index) < rsp_word.entry_count))
		else $error("found index outside the list");

	// Failed commands report index zero
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.status != ST_OK) |-> (rsp_word.found_index == '0))
		else $error("nonzero index on failed command");

endmodule

FILE: hw/rtl/sle_datapath.sv
module sle_datapath #(
	parameter int unsigned CAPACITY = sle_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sle_pkg::cmd_word_t cmd_word,
	input  sle_pkg::dp_ctl_t  ctl,
	output sle_pkg::dp_sts_t  sts,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sle_pkg::rsp_word_t rsp_word
);
	import sle_pkg::*;

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	// List storage, one read and one write port
	logic [VALUE_W-1:0] mem [CAPACITY];

	logic [1:0]         op_q;
	logic [VALUE_W-1:0] word_q;
	logic [POS_W-1:0]   pos_q;
	logic [IW-1:0]      ptr_q;
	logic [CW-1:0]      count_q;
	logic [VALUE_W-1:0] rd_q;
	st_t                status_q;
	logic [IW-1:0]      index_q;
	rsp_word_t          rsp_q;
	logic               rsp_valid_q;

	logic [IW-1:0]      pos_idx;
	logic [POS_W-1:0]   pos_mag;
	logic [POS_W-1:0]   cnt_ext;
	logic [POS_W-1:0]   ptr_ext;
	logic [IW-1:0]      rd_addr;
	logic [IW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;

	assign pos_idx = pos_q[IW-1:0];
	assign pos_mag = {1'b0, pos_q[POS_W-2:0]};
	assign cnt_ext = POS_W'(count_q);
	assign ptr_ext = POS_W'(ptr_q);

	// Status back to the controller
	always_comb begin
		sts.op             = op_q;
		sts.full           = (count_q == CW'(CAPACITY));
		sts.empty          = (count_q == '0);
		sts.ins_ok         = !pos_q[POS_W-1] && (pos_mag <= cnt_ext);
		sts.del_ok         = !pos_q[POS_W-1] && (pos_mag < cnt_ext);
		sts.ins_at_end     = (pos_mag == cnt_ext);
		sts.del_at_end     = (pos_mag + POS_W'(1) == cnt_ext);
		sts.match          = (rd_q == word_q);
		sts.scan_last      = (ptr_ext + POS_W'(1) == cnt_ext);
		sts.ins_next_place = ((ptr_q - IW'(1)) == pos_idx);
		sts.del_last       = (ptr_ext + POS_W'(2) == cnt_ext);
		sts.out_free       = !rsp_valid_q || rsp_ready;
	end

	// Read and write address selection
	always_comb begin
		case (ctl.rd_sel)
			RD_PREV: rd_addr = ptr_q - IW'(1);
			RD_NEXT: rd_addr = ptr_q + IW'(1);
			default: rd_addr = ptr_q;
		endcase
		if (ctl.wr_place) begin
			wr_addr = pos_idx;
			wr_data = word_q;
		end else begin
			wr_addr = ptr_q;
			wr_data = rd_q;
		end
	end

	// Storage ports
	always_ff @(posedge clk) begin
		if (ctl.wr_shift || ctl.wr_place) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Command capture, walk pointer and result fields
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q     <= cmd_word.command;
			word_q   <= cmd_word.value;
			pos_q    <= cmd_word.position;
			status_q <= ST_OK;
			index_q  <= '0;
		end else begin
			if (ctl.st_set) begin
				status_q <= ctl.st_code;
			end
			if (ctl.found_set) begin
				index_q <= ptr_q;
			end
		end
		if (ctl.ptr_init) begin
			case (ctl.ptr_sel)
				PTR_COUNT: ptr_q <= IW'(count_q);
				PTR_POS:   ptr_q <= pos_idx;
				default:   ptr_q <= '0;
			endcase
		end else if (ctl.ptr_inc) begin
			ptr_q <= ptr_q + IW'(1);
		end else if (ctl.ptr_dec) begin
			ptr_q <= ptr_q - IW'(1);
		end
		if (ctl.out_load) begin
			rsp_q.status      <= status_q;
			rsp_q.found_index <= IDX_W'(index_q);
			rsp_q.entry_count <= CNT_W'(count_q);
		end
	end

	// Entry count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

endmodule

FILE: hw/rtl/sle_ctrl.sv
module sle_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  sle_pkg::dp_sts_t sts,
	output sle_pkg::dp_ctl_t ctl
);
	import sle_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_FIND: begin
						if (sts.empty) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_NOT_FOUND;
							state_d     = S_FINISH;
						end else begin
							ctl.ptr_init = 1'b1;
							ctl.ptr_sel  = PTR_ZERO;
							state_d      = S_SCAN_RD;
						end
					end
					OP_INSERT: begin
						if (sts.full) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_FULL;
							state_d     = S_FINISH;
						end else if (!sts.ins_ok) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_BAD_INSERT;
							state_d     = S_FINISH;
						end else begin
							ctl.ptr_init = 1'b1;
							ctl.ptr_sel  = PTR_COUNT;
							state_d      = sts.ins_at_end ? S_PLACE : S_SHIFT_RD;
						end
					end
					OP_DELETE: begin
						if (!sts.del_ok) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_BAD_DELETE;
							state_d     = S_FINISH;
						end else if (sts.del_at_end) begin
							ctl.cnt_dec = 1'b1;
							state_d     = S_FINISH;
						end else begin
							ctl.ptr_init = 1'b1;
							ctl.ptr_sel  = PTR_POS;
							state_d      = S_SHIFT_RD;
						end
					end
					default: begin
						// unused code: list untouched, reports ok
						state_d = S_FINISH;
					end
				endcase
			end
			S_SCAN_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = RD_PTR;
				state_d    = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (sts.match) begin
					ctl.found_set = 1'b1;
					state_d       = S_FINISH;
				end else if (sts.scan_last) begin
					ctl.st_set  = 1'b1;
					ctl.st_code = ST_NOT_FOUND;
					state_d     = S_FINISH;
				end else begin
					ctl.ptr_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_SHIFT_RD: begin
				ctl.rd_en  = 1'b1;
				ctl.rd_sel = (sts.op == OP_INSERT) ? RD_PREV : RD_NEXT;
				state_d    = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				ctl.wr_shift = 1'b1;
				if (sts.op == OP_INSERT) begin
					// moving entries up, walking toward the insert slot
					ctl.ptr_dec = 1'b1;
					state_d     = sts.ins_next_place ? S_PLACE : S_SHIFT_RD;
				end else if (sts.del_last) begin
					ctl.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end else begin
					ctl.ptr_inc = 1'b1;
					state_d     = S_SHIFT_RD;
				end
			end
			S_PLACE: begin
				ctl.wr_place = 1'b1;
				ctl.cnt_inc  = 1'b1;
				state_d      = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: test/tb_sequential_list_engine_top.sv
`timescale 1ns / 100ps

module tb_sequential_list_engine_top;

	import sle_pkg::*;

	localparam int unsigned CAPACITY = CAPACITY_DEF;
	// Worst command: scan or shift the whole list
	localparam int          DRAIN_CYCLES = 2 * CAPACITY + 40;
	localparam int          CYCLE_LIMIT  = 500_000;
	localparam int          LONG_HOLD    = 300;

	// Command code with no operation behind it
	localparam logic [1:0]          OP_UNUSED = 2'd3;
	localparam logic signed [31:0]  WORD_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0]  WORD_MAX  = 32'sh7FFF_FFFF;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_word_t cmd_word  = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp_word;

	// Shadow of the list and queue of responses still owed
	logic signed [31:0] list_q[$];
	rsp_word_t          expected_rsp_q[$];

	int  err_cnt      = 0;
	int  cycle_cnt    = 0;
	int  cmd_total    = 0;
	int  rsp_total    = 0;
	int  full_refused = 0;
	int  peak_fill    = 0;
	int  hold_request = 0;
	bit  src_idle     = 1'b1;
	bit  sink_idle    = 1'b1;

	sequential_list_engine_top #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd_word (cmd_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_word (rsp_word)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Apply one command to the shadow list and return the response it owes
	function automatic rsp_word_t list_apply(input cmd_word_t w);
		rsp_word_t r;
		int        pos;
		bit        hit;
		pos           = $signed(w.position);
		hit           = 1'b0;
		r.status      = ST_OK;
		r.found_index = '0;
		case (w.command)
			OP_FIND: begin
				r.status = ST_NOT_FOUND;
				for (int i = 0; i < list_q.size(); i++) begin
					if (!hit && list_q[i] == w.value) begin
						hit           = 1'b1;
						r.status      = ST_OK;
						r.found_index = IDX_W'(i);
					end
				end
			end
			OP_INSERT: begin
				if (list_q.size() >= CAPACITY) begin
					r.status = ST_FULL;
					full_refused++;
				end else if (pos < 0 || pos > list_q.size()) begin
					r.status = ST_BAD_INSERT;
				end else begin
					list_q.insert(pos, w.value);
				end
			end
			OP_DELETE: begin
				if (list_q.size() == 0 || pos < 0 || pos >= list_q.size())
					r.status = ST_BAD_DELETE;
				else
					list_q.delete(pos);
			end
			default: ;
		endcase
		r.entry_count = CNT_W'(list_q.size());
		if (list_q.size() > peak_fill)
			peak_fill = list_q.size();
		return r;
	endfunction

	// Offer one command word, hold it until taken, then record the response owed
	task automatic send_cmd(input logic [1:0] code, input logic signed [31:0] val,
		input logic signed [7:0] pos);
		cmd_word_t w;
		w.command  = code;
		w.value    = val;
		w.position = pos;
		@(negedge clk);
		if (src_idle && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		expected_rsp_q.push_back(list_apply(w));
		cmd_total++;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[cycle %0d] response %0d: %s = %0d, expected %0d",
			cycle_cnt, rsp_total, what, got, want);
		err_cnt++;
	endtask

	// Response side: random ready bursts plus the long hold on request
	initial begin : rsp_sink
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (sink_idle && $urandom_range(0, 7) == 0) begin
				rsp_ready <= 1'b0;
				stall_left = $urandom_range(0, 12);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Compare every accepted response word with the oldest one owed
	always @(posedge clk) begin : rsp_check
		rsp_word_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				$display("[cycle %0d] response with nothing outstanding", cycle_cnt);
				err_cnt++;
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp_word.status !== want.status)
					report_mismatch("status", rsp_word.status, want.status);
				if (rsp_word.found_index !== want.found_index)
					report_mismatch("found_index", rsp_word.found_index, want.found_index);
				if (rsp_word.entry_count !== want.entry_count)
					report_mismatch("entry_count", rsp_word.entry_count, want.entry_count);
			end
			rsp_total++;
		end
	end

	// Often small values so duplicates occur, sometimes extremes, else anything
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2: pick_value = int'($urandom_range(0, 6)) - 3;
			3:       pick_value = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
			default: pick_value = $urandom;
		endcase
	endfunction

	// Usually a legal index up to legal_hi, otherwise one just outside, an extreme or anything
	function automatic logic signed [7:0] pick_pos(input int legal_hi);
		if (legal_hi >= 0 && $urandom_range(0, 99) < 85)
			return 8'($urandom_range(0, legal_hi));
		case ($urandom_range(0, 3))
			0:       return -8'sd1;
			1:       return 8'(legal_hi + 1);
			2:       return $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Weighted random command mix against the current list contents
	task automatic run_random(input int n_items, input int w_find, input int w_ins,
		input int w_del);
		int                 n;
		int                 pick;
		logic signed [31:0] val;
		for (int k = 0; k < n_items; k++) begin
			n    = list_q.size();
			pick = $urandom_range(0, w_find + w_ins + w_del - 1);
			if ($urandom_range(0, 49) == 0) begin
				send_cmd(OP_UNUSED, $urandom, 8'($urandom_range(0, 255)));
			end else if (pick < w_find) begin
				if (n > 0 && $urandom_range(0, 9) < 6)
					val = list_q[$urandom_range(0, n - 1)];
				else
					val = pick_value();
				send_cmd(OP_FIND, val, 8'($urandom_range(0, 255)));
			end else if (pick < w_find + w_ins) begin
				send_cmd(OP_INSERT, pick_value(), pick_pos(n));
			end else begin
				send_cmd(OP_DELETE, $urandom, pick_pos(n - 1));
			end
		end
	endtask

	// Corner cases on a freshly reset list
	task automatic test_directed();
		send_cmd(OP_FIND,   32'sd0,       8'sd0);     // find on empty
		send_cmd(OP_DELETE, 32'sd0,       8'sd0);     // delete on empty
		send_cmd(OP_INSERT, 32'sd9,       8'sd1);     // beyond count
		send_cmd(OP_INSERT, 32'sd9,       -8'sd1);    // negative
		send_cmd(OP_INSERT, WORD_MIN,     8'sd0);
		send_cmd(OP_INSERT, WORD_MAX,     8'sd1);     // append at count
		send_cmd(OP_INSERT, 32'sd0,       8'sd1);     // middle
		send_cmd(OP_INSERT, -32'sd1,      8'sd0);     // front
		send_cmd(OP_INSERT, 32'sd0,       8'sd4);     // duplicate at end
		send_cmd(OP_FIND,   32'sd0,       8'sd0);     // first of two matches
		send_cmd(OP_FIND,   WORD_MAX,     -8'sd128);
		send_cmd(OP_FIND,   32'sd12345,   8'sd0);     // miss
		send_cmd(OP_INSERT, 32'sd1,       8'sd127);
		send_cmd(OP_INSERT, 32'sd1,       -8'sd128);
		send_cmd(OP_DELETE, 32'sd0,       8'sd5);     // at count
		send_cmd(OP_DELETE, 32'sd0,       -8'sd128);
		send_cmd(OP_DELETE, 32'sd0,       8'sd127);
		send_cmd(OP_UNUSED, 32'h5A5A_A5A5, -8'sd77);  // ignored code
		send_cmd(OP_DELETE, 32'sd0,       8'sd0);     // front
		send_cmd(OP_DELETE, 32'sd0,       8'sd3);     // last
		send_cmd(OP_DELETE, 32'sd0,       8'sd1);     // middle
		send_cmd(OP_FIND,   WORD_MIN,     8'sd0);
		send_cmd(OP_INSERT, 32'h5555_AAAA, 8'sd2);
	endtask

	// Insert-heavy traffic runs the list into full and keeps pushing
	task automatic test_fill_and_overflow();
		run_random(110, 2, 8, 1);
	endtask

	// Delete-heavy traffic empties the list and keeps deleting
	task automatic test_drain();
		run_random(100, 2, 1, 8);
	endtask

	// Response side stops for a long stretch while commands keep coming
	task automatic test_backpressure();
		hold_request = LONG_HOLD;
		run_random(8, 1, 1, 1);
	endtask

	task automatic test_mixed();
		run_random(390, 3, 3, 2);
	endtask

	task automatic test_back_to_back();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		run_random(120, 3, 3, 2);
	endtask

	initial begin : watchdog
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d responses outstanding",
			cycle_cnt, expected_rsp_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : main
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill_and_overflow();
		test_drain();
		test_backpressure();
		test_mixed();
		test_back_to_back();

		@(negedge clk);
		cmd_valid <= 1'b0;
		wait (expected_rsp_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d commands, %0d responses checked, %0d mismatches",
			cmd_total, rsp_total, err_cnt);
		$display("List peaked at %0d of %0d entries; %0d inserts refused as full",
			peak_fill, CAPACITY, full_refused);
		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_datapath.sv
hw/rtl/sle_ctrl.sv
hw/rtl/sequential_list_engine_top.sv
test/tb_sequential_list_engine_top.sv
